// ===== hw/rtl/iflp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package iflp_pkg;

    // parser states, one-hot
    typedef enum logic [6:0] {
        ST_START = 7'b0000001,
        ST_ZERO  = 7'b0000010,
        ST_DEC   = 7'b0000100,
        ST_MINUS = 7'b0001000,
        ST_HEX0  = 7'b0010000,
        ST_HEX   = 7'b0100000,
        ST_TRAIL = 7'b1000000
    } state_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_SYNTAX = 2'd1,
        STAT_OVF    = 2'd2,
        STAT_SOVF   = 2'd3
    } status_t;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 64;

    // character codes
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_F     = 8'h66;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

endpackage

`default_nettype wire

// ===== hw/rtl/iflp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// character channel
interface iflp_char_if;
    logic                         valid;
    logic                         ready;
    logic [iflp_pkg::CHAR_W-1:0]  ch;
    logic                         last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

// result channel
interface iflp_result_if;
    logic                          valid;
    logic                          ready;
    logic [iflp_pkg::VALUE_W-1:0]  value;
    logic [1:0]                    status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/integer_literal_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Streaming integer literal parser. One ASCII character is taken per transaction on
// chars, with last marking the end of a literal; each literal gives one transaction on
// results carrying the 64-bit value (two's complement when negative, zero on error) and
// a status (0 ok, 1 syntax, 2 overflow, 3 negative magnitude too large). The unit takes
// one character every clock cycle unless a stalled result holds characters back: the
// per-character step is a single shift-add multiply by 10 or 16 with its carry check,
// done combinationally between the input register and the parser state registers. A
// result passes from the input register through the finish register to the output
// register, which does the negation; each stage moves on its own, so a stalled result
// holds characters back only once the finish register is also full and the last
// character of a further literal has reached the input register.
module integer_literal_parser_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    iflp_char_if.sink         chars,
    iflp_result_if.source     results
);

    localparam int VW = iflp_pkg::VALUE_W;

    // input register
    logic                         i_valid_reg;
    logic [iflp_pkg::CHAR_W-1:0]  ch_reg;
    logic                         last_reg;

    // parser state
    iflp_pkg::state_t             state_reg, state_next;
    logic [VW-1:0]                acc_reg, acc_next;
    logic                         neg_reg, neg_next;
    iflp_pkg::status_t            err_reg, err_next;

    // finish register
    logic                         f_valid_reg;
    logic [VW-1:0]                f_mag_reg;
    logic                         f_neg_reg;
    iflp_pkg::status_t            f_status_reg;
    iflp_pkg::status_t            f_status_next;

    // output register
    logic                         o_valid_reg;
    logic [VW-1:0]                o_value_reg;
    iflp_pkg::status_t            o_status_reg;

    logic o_en, f_en, proc, i_en;

    // stage handshakes
    assign o_en  = !o_valid_reg || results.ready;
    assign f_en  = !f_valid_reg || o_en;
    assign proc  = i_valid_reg && (!last_reg || f_en);
    assign i_en  = !i_valid_reg || proc;
    assign chars.ready = i_en;

    // character classes
    logic is_space, is_minus, is_zero, is_nz, is_dec, is_hexl, is_x;
    assign is_space = (ch_reg == iflp_pkg::CH_SPACE);
    assign is_minus = (ch_reg == iflp_pkg::CH_MINUS);
    assign is_zero  = (ch_reg == iflp_pkg::CH_ZERO);
    assign is_nz    = (ch_reg >= iflp_pkg::CH_ONE) && (ch_reg <= iflp_pkg::CH_NINE);
    assign is_dec   = is_zero || is_nz;
    assign is_hexl  = (ch_reg >= iflp_pkg::CH_A) && (ch_reg <= iflp_pkg::CH_F);
    assign is_x     = (ch_reg == iflp_pkg::CH_X);

    // digit value and the two multiply-adds
    logic [3:0]    digit;
    logic [VW+3:0] sum10;
    logic          ovf10, ovf16;
    logic [VW-1:0] sum16;
    assign digit = is_dec ? ch_reg[3:0] : (ch_reg[3:0] + 4'd9);
    assign sum10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + {{VW{1'b0}}, digit};
    assign ovf10 = |sum10[VW+3:VW];
    assign ovf16 = |acc_reg[VW-1:VW-4];
    assign sum16 = {acc_reg[VW-5:0], digit};

    // next parser state for the character in the input register
    iflp_pkg::state_t st_c;
    logic             bad;
    always_comb
    begin
        st_c = state_reg;
        bad  = 1'b0;
        unique case (state_reg)
            iflp_pkg::ST_START:
            begin
                if (is_space)      st_c = iflp_pkg::ST_START;
                else if (is_zero)  st_c = iflp_pkg::ST_ZERO;
                else if (is_nz)    st_c = iflp_pkg::ST_DEC;
                else if (is_minus) st_c = iflp_pkg::ST_MINUS;
                else               bad  = 1'b1;
            end
            iflp_pkg::ST_ZERO:
            begin
                if (is_x)          st_c = iflp_pkg::ST_HEX0;
                else if (is_dec)   st_c = iflp_pkg::ST_DEC;
                else if (is_space) st_c = iflp_pkg::ST_TRAIL;
                else               bad  = 1'b1;
            end
            iflp_pkg::ST_DEC:
            begin
                if (is_dec)        st_c = iflp_pkg::ST_DEC;
                else if (is_space) st_c = iflp_pkg::ST_TRAIL;
                else               bad  = 1'b1;
            end
            iflp_pkg::ST_MINUS:
            begin
                if (is_zero)       st_c = iflp_pkg::ST_ZERO;
                else if (is_nz)    st_c = iflp_pkg::ST_DEC;
                else               bad  = 1'b1;
            end
            iflp_pkg::ST_HEX0:
            begin
                if (is_dec || is_hexl) st_c = iflp_pkg::ST_HEX;
                else                   bad  = 1'b1;
            end
            iflp_pkg::ST_HEX:
            begin
                if (is_dec || is_hexl) st_c = iflp_pkg::ST_HEX;
                else if (is_space)     st_c = iflp_pkg::ST_TRAIL;
                else                   bad  = 1'b1;
            end
            iflp_pkg::ST_TRAIL:
            begin
                if (is_space) st_c = iflp_pkg::ST_TRAIL;
                else          bad  = 1'b1;
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase
    end

    // consume one character; errors are sticky
    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        err_next   = err_reg;
        if (err_reg == iflp_pkg::STAT_OK)
        begin
            if (bad)
            begin
                err_next = iflp_pkg::STAT_SYNTAX;
            end
            else
            begin
                state_next = st_c;
                if (st_c == iflp_pkg::ST_DEC && is_dec)
                begin
                    if (ovf10) err_next = iflp_pkg::STAT_OVF;
                    else       acc_next = sum10[VW-1:0];
                end
                else if (st_c == iflp_pkg::ST_MINUS)
                begin
                    neg_next = 1'b1;
                end
                else if (st_c == iflp_pkg::ST_HEX)
                begin
                    if (ovf16) err_next = iflp_pkg::STAT_OVF;
                    else       acc_next = sum16;
                end
            end
        end
    end

    // final status at the end of a literal
    always_comb
    begin
        if (err_next != iflp_pkg::STAT_OK)
            f_status_next = err_next;
        else if (state_next == iflp_pkg::ST_START || state_next == iflp_pkg::ST_MINUS ||
                 state_next == iflp_pkg::ST_HEX0)
            f_status_next = iflp_pkg::STAT_SYNTAX;
        else if (neg_next && acc_next[VW-1] && (|acc_next[VW-2:0]))
            f_status_next = iflp_pkg::STAT_SOVF;
        else
            f_status_next = iflp_pkg::STAT_OK;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            state_reg   <= iflp_pkg::ST_START;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            err_reg     <= iflp_pkg::STAT_OK;
        end
        else
        begin
            if (i_en)
                i_valid_reg <= chars.valid;
            if (f_en)
                f_valid_reg <= proc && last_reg;
            if (o_en)
                o_valid_reg <= f_valid_reg;
            if (proc)
            begin
                if (last_reg)
                begin
                    state_reg <= iflp_pkg::ST_START;
                    acc_reg   <= '0;
                    neg_reg   <= 1'b0;
                    err_reg   <= iflp_pkg::STAT_OK;
                end
                else
                begin
                    state_reg <= state_next;
                    acc_reg   <= acc_next;
                    neg_reg   <= neg_next;
                    err_reg   <= err_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (i_en && chars.valid)
        begin
            ch_reg   <= chars.ch;
            last_reg <= chars.last;
        end
        if (f_en && proc && last_reg)
        begin
            f_mag_reg    <= acc_next;
            f_neg_reg    <= neg_next;
            f_status_reg <= f_status_next;
        end
        if (o_en && f_valid_reg)
        begin
            o_status_reg <= f_status_reg;
            if (f_status_reg != iflp_pkg::STAT_OK)
                o_value_reg <= '0;
            else if (f_neg_reg)
                o_value_reg <= ~f_mag_reg + {{(VW-1){1'b0}}, 1'b1};
            else
                o_value_reg <= f_mag_reg;
        end
    end

    assign results.valid  = o_valid_reg;
    assign results.value  = o_value_reg;
    assign results.status = o_status_reg;

endmodule

`default_nettype wire
